FILE: design/lss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg
// Shared constants, types and helpers of the rangefinder sector statistics.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int NUM_SECTORS    = 6;
  localparam int COUNT_BITS     = 12;
  localparam int DIST_BITS      = 16;
  localparam int ANGLE_BITS     = 19;
  localparam int SUM_BITS       = COUNT_BITS + DIST_BITS;
  localparam int SEC_BITS       = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;
  localparam int BIN_BITS       = $clog2(NUM_SECTORS + 1);
  localparam int THR_BITS       = ANGLE_BITS + BIN_BITS;
  localparam int DIV_CNT_BITS   = $clog2(SUM_BITS);

  localparam int OUT_INDEX_BITS = 3;
  localparam int OUT_AVG_BITS   = 16;
  localparam int OUT_COUNT_BITS = 12;

  localparam int CFG_ADDR_BITS  = 4;
  localparam int CFG_DATA_BITS  = 19;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

  // register indexes
  localparam logic [CFG_ADDR_BITS-1:0] CFG_SECTOR_WIDTH  = 4'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_CLIP_DISTANCE = 4'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_NEAR_LIMIT    = 4'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_CLOSE_LIMIT   = 4'd3;

  localparam logic [ANGLE_BITS-1:0] SECTOR_WIDTH_RST  = 19'd30000;
  localparam logic [DIST_BITS-1:0]  CLIP_DISTANCE_RST = 16'd800;
  localparam logic [DIST_BITS-1:0]  NEAR_LIMIT_RST    = 16'd200;
  localparam logic [DIST_BITS-1:0]  CLOSE_LIMIT_RST   = 16'd1000;

  // one classified sample, front to back
  typedef struct packed {
    logic                 new_rev;
    logic                 binned;
    logic [SEC_BITS-1:0]  idx;
    logic [DIST_BITS-1:0] add;
    logic                 near;
    logic                 close;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [OUT_COUNT_BITS-1:0] cap_count(input logic [COUNT_BITS-1:0] v);
    logic [OUT_COUNT_BITS-1:0] r;
    if ((v >> OUT_COUNT_BITS) != '0) begin
      r = '1;
    end else begin
      r = OUT_COUNT_BITS'(v);
    end
    return r;
  endfunction

  function automatic logic [OUT_AVG_BITS-1:0] cap_avg(input logic [SUM_BITS-1:0] v);
    logic [OUT_AVG_BITS-1:0] r;
    if ((v >> OUT_AVG_BITS) != '0) begin
      r = '1;
    end else begin
      r = OUT_AVG_BITS'(v);
    end
    return r;
  endfunction

endpackage

FILE: design/lss_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_sample_if
// Sample channel: bearing and range with valid/ready.
// ----------------------------------------------------------------------------
interface lss_sample_if;
  import lss_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] sample_angle;
  logic [DIST_BITS-1:0]  sample_distance;

  modport source (output valid, sample_angle, sample_distance, input ready);
  modport sink   (input valid, sample_angle, sample_distance, output ready);
endinterface

FILE: design/lss_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_result_if
// Summary row channel: one row per sector with valid/ready.
// ----------------------------------------------------------------------------
interface lss_result_if;
  import lss_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OUT_INDEX_BITS-1:0] sector_index;
  logic [OUT_AVG_BITS-1:0]   sector_average;
  logic                      average_valid;
  logic [OUT_COUNT_BITS-1:0] near_hits;
  logic [OUT_COUNT_BITS-1:0] sector_total;
  logic [OUT_COUNT_BITS-1:0] close_hits;
  logic                      last_of_scan;

  modport source (output valid, sector_index, sector_average, average_valid, near_hits,
                  sector_total, close_hits, last_of_scan, input ready);
  modport sink   (input valid, sector_index, sector_average, average_valid, near_hits,
                  sector_total, close_hits, last_of_scan, output ready);
endinterface

FILE: design/lss_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_cfg_if
// Register write channel: address and data with valid/ready.
// ----------------------------------------------------------------------------
interface lss_cfg_if;
  import lss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_ADDR_BITS-1:0] addr;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

FILE: design/lidar_sector_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_sector_statistics
// Bins rangefinder samples into angular sectors and reports per-sector
// statistics once per revolution.
// ----------------------------------------------------------------------------
//  port     dir   payload
//  sample   in    sample_angle, sample_distance
//  result   out   sector_index, sector_average, average_valid, near_hits,
//                 sector_total, close_hits, last_of_scan
//  cfg      in    addr (register index), data
//
//  front end takes one sample per cycle, while the queue is not full, into a four-entry command queue
//  accumulator dequeues each sample, then does a read-modify-write, before the next
//  a revolution adds one row per sector, six rows in all; a sector with samples
//  waits on the serial divide, an empty sector skips it
//  rst is synchronous: registers return to defaults, accumulators clear
//  a stalled result holds the output register; until it fills, the queue keeps taking samples
// ----------------------------------------------------------------------------
module lidar_sector_statistics (
  input  logic         clk,
  input  logic         rst,
  lss_sample_if.sink   sample,
  lss_result_if.source result,
  lss_cfg_if.sink      cfg
);
  import lss_pkg::*;

  cmd_t      push_cmd;
  cmd_t      head;
  logic      q_push;
  logic      q_pop;
  q_status_t q_status;

  lss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .cfg      (cfg),
    .cmd      (push_cmd),
    .push     (q_push),
    .q_status (q_status)
  );

  lss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .status   (q_status)
  );

  lss_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (q_pop),
    .result   (result)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("command pushed into full queue");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> !q_status.empty)
    else $error("queue empty after push");

  a_empty_avg: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.average_valid) |-> (result.sector_average == '0))
    else $error("empty sector with nonzero average");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.last_of_scan) |->
      (result.sector_index == OUT_INDEX_BITS'(NUM_SECTORS - 1)))
    else $error("last row flag on wrong sector");

endmodule

FILE: design/lss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_front
// Holds the registers, takes samples, bins them and detects a new revolution.
// ----------------------------------------------------------------------------
module lss_front (
  input  logic            clk,
  input  logic            rst,
  lss_sample_if.sink      sample,
  lss_cfg_if.sink         cfg,
  output lss_pkg::cmd_t   cmd,
  output logic            push,
  input  lss_pkg::q_status_t q_status
);
  import lss_pkg::*;

  logic [ANGLE_BITS-1:0] sector_width;
  logic [DIST_BITS-1:0]  clip_distance;
  logic [DIST_BITS-1:0]  near_limit;
  logic [DIST_BITS-1:0]  close_limit;

  logic                  hold_v;
  logic [ANGLE_BITS-1:0] hold_angle;
  logic [DIST_BITS-1:0]  hold_dist;
  logic [ANGLE_BITS-1:0] previous_angle;

  logic [BIN_BITS-1:0]   bin;
  logic                  clipped;

  assign cfg.ready    = 1'b1;
  assign sample.ready = !hold_v || !q_status.full;
  assign push         = hold_v && !q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_width  <= SECTOR_WIDTH_RST;
      clip_distance <= CLIP_DISTANCE_RST;
      near_limit    <= NEAR_LIMIT_RST;
      close_limit   <= CLOSE_LIMIT_RST;
    end else if (cfg.valid) begin
      case (cfg.addr)
        CFG_SECTOR_WIDTH:  sector_width  <= cfg.data[ANGLE_BITS-1:0];
        CFG_CLIP_DISTANCE: clip_distance <= cfg.data[DIST_BITS-1:0];
        CFG_NEAR_LIMIT:    near_limit    <= cfg.data[DIST_BITS-1:0];
        CFG_CLOSE_LIMIT:   close_limit   <= cfg.data[DIST_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v         <= 1'b0;
      previous_angle <= '0;
    end else begin
      if (sample.valid && sample.ready) begin
        hold_v <= 1'b1;
      end else if (push) begin
        hold_v <= 1'b0;
      end
      if (push) begin
        previous_angle <= hold_angle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      hold_angle <= sample.sample_angle;
      hold_dist  <= sample.sample_distance;
    end
  end

  // sector = number of sector boundaries at or below the angle
  always_comb begin
    bin = '0;
    for (int k = 0; k < NUM_SECTORS; k++) begin
      if (THR_BITS'(hold_angle) >= THR_BITS'(sector_width) * THR_BITS'(k + 1)) begin
        bin = bin + 1'b1;
      end
    end
  end

  assign clipped = hold_dist > clip_distance;

  always_comb begin
    cmd.new_rev = hold_angle < previous_angle;
    cmd.binned  = bin < BIN_BITS'(NUM_SECTORS);
    cmd.idx     = SEC_BITS'(bin);
    cmd.add     = clipped ? clip_distance : hold_dist;
    cmd.near    = !clipped && (hold_dist < near_limit);
    cmd.close   = hold_dist < close_limit;
  end

endmodule

FILE: design/lss_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_queue
// Short command queue between the sample front end and the accumulator.
// ----------------------------------------------------------------------------
module lss_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lss_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output lss_pkg::cmd_t      head,
  output lss_pkg::q_status_t status
);
  import lss_pkg::*;

  cmd_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   fill;

  assign head         = entries[rd_ptr];
  assign status.full  = fill == (QPTR_BITS + 1)'(QUEUE_DEPTH);
  assign status.empty = fill == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: design/lss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_div
// Restoring divider, one quotient bit per cycle: clipped sum / sample total.
// ----------------------------------------------------------------------------
module lss_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [lss_pkg::SUM_BITS-1:0]   dividend,
  input  logic [lss_pkg::COUNT_BITS-1:0] divisor,
  output logic                           busy,
  output logic [lss_pkg::SUM_BITS-1:0]   quotient
);
  import lss_pkg::*;

  logic [COUNT_BITS-1:0]   rem;
  logic [DIV_CNT_BITS-1:0] step;
  logic [COUNT_BITS:0]     trial;
  logic                    fits;

  assign trial = {rem, quotient[SUM_BITS-1]};
  assign fits  = trial >= (COUNT_BITS + 1)'(divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && step == '0) begin
      busy <= 1'b0;
    end
  end

  // dividend shifts out of the top while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      step     <= DIV_CNT_BITS'(SUM_BITS - 1);
    end else if (busy) begin
      quotient <= {quotient[SUM_BITS-2:0], fits};
      rem      <= fits ? COUNT_BITS'(trial - (COUNT_BITS + 1)'(divisor))
                       : trial[COUNT_BITS-1:0];
      step     <= step - 1'b1;
    end
  end

endmodule

FILE: design/lss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_back
// Per-sector accumulators, revolution summary rows and the output register.
// ----------------------------------------------------------------------------
module lss_back (
  input  logic               clk,
  input  logic               rst,
  input  lss_pkg::cmd_t      head,
  input  lss_pkg::q_status_t q_status,
  output logic               pop,
  lss_result_if.source       result
);
  import lss_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ROW  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_ACC  = 5'b10000
  } state_t;

  state_t                state;
  cmd_t                  cur;
  logic [SEC_BITS-1:0]   row;

  logic [SUM_BITS-1:0]   sums   [NUM_SECTORS];
  logic [COUNT_BITS-1:0] nears  [NUM_SECTORS];
  logic [COUNT_BITS-1:0] tots   [NUM_SECTORS];
  logic [COUNT_BITS-1:0] close_cnt;

  logic [SEC_BITS-1:0]   sel;
  logic [SUM_BITS-1:0]   rd_sum;
  logic [COUNT_BITS-1:0] rd_near;
  logic [COUNT_BITS-1:0] rd_tot;
  logic [SUM_BITS:0]     sum_wide;
  logic [SUM_BITS-1:0]   sum_next;
  logic                  has_samples;
  logic                  last_row;
  logic                  out_free;
  logic                  div_start;
  logic                  div_busy;
  logic [SUM_BITS-1:0]   quotient;

  logic                      out_v;
  logic [OUT_INDEX_BITS-1:0] out_index;
  logic [OUT_AVG_BITS-1:0]   out_avg;
  logic                      out_avg_valid;
  logic [OUT_COUNT_BITS-1:0] out_near;
  logic [OUT_COUNT_BITS-1:0] out_total;
  logic [OUT_COUNT_BITS-1:0] out_close;
  logic                      out_last;

  assign pop = (state == ST_IDLE) && !q_status.empty;

  // one read port: the row being summarized or the sector being updated
  assign sel      = (state == ST_ACC) ? cur.idx : row;
  assign rd_sum   = sums[sel];
  assign rd_near  = nears[sel];
  assign rd_tot   = tots[sel];
  assign sum_wide = (SUM_BITS + 1)'(rd_sum) + (SUM_BITS + 1)'(cur.add);
  assign sum_next = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];

  assign has_samples = rd_tot != '0;
  assign last_row    = row == SEC_BITS'(NUM_SECTORS - 1);
  assign out_free    = !out_v || result.ready;
  assign div_start   = (state == ST_ROW) && has_samples;

  lss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_sum),
    .divisor  (rd_tot),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row       <= '0;
      close_cnt <= '0;
      for (int s = 0; s < NUM_SECTORS; s++) begin
        sums[s]  <= '0;
        nears[s] <= '0;
        tots[s]  <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_status.empty) begin
            row   <= '0;
            state <= head.new_rev ? ST_ROW : ST_ACC;
          end
        end
        ST_ROW: begin
          state <= has_samples ? ST_DIV : ST_EMIT;
        end
        ST_DIV: begin
          if (!div_busy) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (last_row) begin
              close_cnt <= '0;
              for (int s = 0; s < NUM_SECTORS; s++) begin
                sums[s]  <= '0;
                nears[s] <= '0;
                tots[s]  <= '0;
              end
              state <= ST_ACC;
            end else begin
              row   <= row + 1'b1;
              state <= ST_ROW;
            end
          end
        end
        ST_ACC: begin
          if (cur.binned) begin
            sums[cur.idx] <= sum_next;
            tots[cur.idx] <= (rd_tot == '1) ? rd_tot : rd_tot + 1'b1;
            if (cur.near) begin
              nears[cur.idx] <= (rd_near == '1) ? rd_near : rd_near + 1'b1;
            end
          end
          if (cur.close && close_cnt != '1) begin
            close_cnt <= close_cnt + 1'b1;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      out_v <= 1'b1;
    end else if (result.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      out_index     <= OUT_INDEX_BITS'(row);
      out_avg       <= has_samples ? cap_avg(quotient) : '0;
      out_avg_valid <= has_samples;
      out_near      <= cap_count(rd_near);
      out_total     <= cap_count(rd_tot);
      out_close     <= cap_count(close_cnt);
      out_last      <= last_row;
    end
  end

  assign result.valid          = out_v;
  assign result.sector_index   = out_index;
  assign result.sector_average = out_avg;
  assign result.average_valid  = out_avg_valid;
  assign result.near_hits      = out_near;
  assign result.sector_total   = out_total;
  assign result.close_hits     = out_close;
  assign result.last_of_scan   = out_last;

endmodule

FILE: verif/tb_lidar_sector_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lidar_sector_statistics
// Feeds bearing/range samples and register writes into the sector statistics
// block and checks every summary row, field by field, against a cycle-free
// model of the binning, clipping, counting and per-revolution averaging.
// A directed table comes first, then random sweeps under several settings,
// a long output stall, and a burst into one sector with no idling on
// either side.
// ----------------------------------------------------------------------------
module tb_lidar_sector_statistics;
  import lss_pkg::*;

  localparam int SETTLE_CYCLES = 60;
  localparam int DRAIN_CYCLES  = 300;
  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 45;
  localparam int NUM_PHASES    = 5;
  localparam int FLOOD_ITEMS   = 50;
  localparam int FLOOD_BASE    = 60000;
  localparam int ANGLE_LAST    = 359999;
  localparam int DIST_MAX      = 65535;
  localparam int PLAN_LEN      = 30;

  // not a register: writes there must be dropped
  localparam logic [CFG_ADDR_BITS-1:0] CFG_NO_REG = 4'hF;

  localparam logic [SUM_BITS-1:0] SUM_FULL = '1;
  localparam logic [SUM_BITS-1:0] AVG_TOP  = SUM_BITS'(DIST_MAX);

  typedef struct {
    logic [OUT_INDEX_BITS-1:0] sector_index;
    logic [OUT_AVG_BITS-1:0]   sector_average;
    logic                      average_valid;
    logic [OUT_COUNT_BITS-1:0] near_hits;
    logic [OUT_COUNT_BITS-1:0] sector_total;
    logic [OUT_COUNT_BITS-1:0] close_hits;
    logic                      last_of_scan;
  } sector_row_t;

  typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_t;

  typedef struct {
    step_kind_t               kind;
    logic [CFG_ADDR_BITS-1:0] addr;
    logic [CFG_DATA_BITS-1:0] data;
    logic [ANGLE_BITS-1:0]    angle;
    logic [DIST_BITS-1:0]     dist_cm;
    bit                       typed;
    bit                       t_empty;
    int                       t_close;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  lss_sample_if smp ();
  lss_result_if res ();
  lss_cfg_if    cfg_ch ();

  lidar_sector_statistics u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .result (res),
    .cfg    (cfg_ch)
  );

  // model copy of the registers and accumulators
  logic [ANGLE_BITS-1:0] cfg_width;
  logic [DIST_BITS-1:0]  cfg_clip;
  logic [DIST_BITS-1:0]  cfg_near;
  logic [DIST_BITS-1:0]  cfg_close;
  logic [SUM_BITS-1:0]   sec_sum   [NUM_SECTORS];
  logic [COUNT_BITS-1:0] sec_near  [NUM_SECTORS];
  logic [COUNT_BITS-1:0] sec_total [NUM_SECTORS];
  logic [COUNT_BITS-1:0] close_cnt;
  logic [ANGLE_BITS-1:0] last_angle;

  sector_row_t scan_rows [NUM_SECTORS];
  sector_row_t rows_due [$];
  sector_row_t want;

  int mismatches   = 0;
  int quiet_cycles = 0;
  int hold_left    = 0;
  bit hold_req     = 1'b0;
  bit hold_done    = 1'b0;
  bit no_idle      = 1'b0;

  step_t plan [PLAN_LEN] = '{
    // first sample after reset never opens a revolution
    '{STEP_SAMPLE, '0, '0, 19'd0,      16'd0,     1'b0, 1'b0, 0},
    // beyond the last sector, far range
    '{STEP_SAMPLE, '0, '0, 19'd359999, 16'd65535, 1'b0, 1'b0, 0},
    '{STEP_SAMPLE, '0, '0, 19'd0,      16'd500,   1'b1, 1'b0, 1},
    '{STEP_SAMPLE, '0, '0, 19'd29999,  16'd199,   1'b0, 1'b0, 0},
    '{STEP_SAMPLE, '0, '0, 19'd30000,  16'd200,   1'b0, 1'b0, 0},
    '{STEP_SAMPLE, '0, '0, 19'd59999,  16'd800,   1'b0, 1'b0, 0},
    '{STEP_SAMPLE, '0, '0, 19'd60000,  16'd801,   1'b0, 1'b0, 0},
    '{STEP_SAMPLE, '0, '0, 19'd149999, 16'd999,   1'b0, 1'b0, 0},
    '{STEP_SAMPLE, '0, '0, 19'd150000, 16'd1000,  1'b0, 1'b0, 0},
    '{STEP_SAMPLE, '0, '0, 19'd179999, 16'd65535, 1'b0, 1'b0, 0},
    '{STEP_SAMPLE, '0, '0, 19'd180000, 16'd12345, 1'b0, 1'b0, 0},
    '{STEP_SAMPLE, '0, '0, 19'd100,    16'd0,     1'b1, 1'b0, 6},
    // equal angle is not a drop
    '{STEP_SAMPLE, '0, '0, 19'd100,    16'd0,     1'b0, 1'b0, 0},
    '{STEP_SAMPLE, '0, '0, 19'd99,     16'd0,     1'b1, 1'b0, 2},
    '{STEP_SAMPLE, '0, '0, 19'd0,      16'd65535, 1'b1, 1'b0, 1},
    '{STEP_SAMPLE, '0, '0, 19'd359999, 16'd5,     1'b0, 1'b0, 0},
    '{STEP_SAMPLE, '0, '0, 19'd200000, 16'd2000,  1'b1, 1'b0, 1},
    // revolutions with every sector empty
    '{STEP_SAMPLE, '0, '0, 19'd190000, 16'd1,     1'b1, 1'b1, 0},
    '{STEP_SAMPLE, '0, '0, 19'd0,      16'd0,     1'b1, 1'b1, 1},
    // zero width, clip below near, upper data bits must be ignored
    '{STEP_WRITE, CFG_SECTOR_WIDTH,  19'd0,     '0, '0, 1'b0, 1'b0, 0},
    '{STEP_WRITE, CFG_CLIP_DISTANCE, 19'h70064, '0, '0, 1'b0, 1'b0, 0},
    '{STEP_WRITE, CFG_NEAR_LIMIT,    19'h7FFFF, '0, '0, 1'b0, 1'b0, 0},
    '{STEP_WRITE, CFG_CLOSE_LIMIT,   19'h50000, '0, '0, 1'b0, 1'b0, 0},
    '{STEP_WRITE, CFG_NO_REG,        19'h7FFFF, '0, '0, 1'b0, 1'b0, 0},
    '{STEP_SAMPLE, '0, '0, 19'd5000,   16'd50,    1'b0, 1'b0, 0},
    '{STEP_SAMPLE, '0, '0, 19'd4999,   16'd0,     1'b0, 1'b0, 0},
    '{STEP_SAMPLE, '0, '0, 19'd4998,   16'd100,   1'b1, 1'b1, 0},
    '{STEP_WRITE, CFG_SECTOR_WIDTH,  19'd360000, '0, '0, 1'b0, 1'b0, 0},
    // clipped sample is never near, even with near limit above it
    '{STEP_SAMPLE, '0, '0, 19'd359999, 16'd150,   1'b0, 1'b0, 0},
    '{STEP_SAMPLE, '0, '0, 19'd0,      16'd100,   1'b0, 1'b0, 0}
  };

  function automatic void clear_sectors();
    for (int s = 0; s < NUM_SECTORS; s++) begin
      sec_sum[s]   = '0;
      sec_near[s]  = '0;
      sec_total[s] = '0;
    end
    close_cnt = '0;
  endfunction

  // folds one sample into the model, returns the number of rows it releases
  function automatic int bin_sample(input logic [ANGLE_BITS-1:0] ang,
                                    input logic [DIST_BITS-1:0] dist_cm);
    int                   n;
    int unsigned          bin;
    logic [SUM_BITS-1:0]  quo;
    logic [SUM_BITS:0]    grown;
    logic [DIST_BITS-1:0] add;
    n = 0;
    if (ang < last_angle) begin
      for (int s = 0; s < NUM_SECTORS; s++) begin
        scan_rows[s].sector_index   = OUT_INDEX_BITS'(s);
        scan_rows[s].sector_average = '0;
        scan_rows[s].average_valid  = 1'b0;
        if (sec_total[s] != '0) begin
          quo = sec_sum[s] / SUM_BITS'(sec_total[s]);
          scan_rows[s].sector_average = (quo > AVG_TOP) ? '1 : OUT_AVG_BITS'(quo);
          scan_rows[s].average_valid  = 1'b1;
        end
        scan_rows[s].near_hits    = sec_near[s];
        scan_rows[s].sector_total = sec_total[s];
        scan_rows[s].close_hits   = close_cnt;
        scan_rows[s].last_of_scan = (s == NUM_SECTORS - 1);
      end
      n = NUM_SECTORS;
      clear_sectors();
    end
    if (cfg_width != '0) begin
      bin = 32'(ang / cfg_width);
      if (bin < NUM_SECTORS) begin
        if (dist_cm > cfg_clip) begin
          add = cfg_clip;
        end else begin
          add = dist_cm;
          if (dist_cm < cfg_near && sec_near[bin] != '1) sec_near[bin]++;
        end
        grown = {1'b0, sec_sum[bin]} + add;
        sec_sum[bin] = (grown > {1'b0, SUM_FULL}) ? SUM_FULL : grown[SUM_BITS-1:0];
        if (sec_total[bin] != '1) sec_total[bin]++;
      end
    end
    if (dist_cm < cfg_close && close_cnt != '1) close_cnt++;
    last_angle = ang;
    return n;
  endfunction

  task automatic send_sample(input logic [ANGLE_BITS-1:0] ang,
                             input logic [DIST_BITS-1:0] dist_cm,
                             input bit typed = 1'b0, input bit t_empty = 1'b0,
                             input int t_close = 0);
    int n;
    while (!no_idle && $urandom_range(99) < 32) begin
      smp.valid = 1'b0;
      @(negedge clk);
    end
    smp.valid           = 1'b1;
    smp.sample_angle    = ang;
    smp.sample_distance = dist_cm;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    n = bin_sample(ang, dist_cm);
    for (int i = 0; i < n; i++) begin
      // hand-known values replace the model's on table rows that carry them
      if (typed) begin
        scan_rows[i].close_hits = OUT_COUNT_BITS'(t_close);
        if (t_empty) begin
          scan_rows[i].sector_average = '0;
          scan_rows[i].average_valid  = 1'b0;
          scan_rows[i].near_hits      = '0;
          scan_rows[i].sector_total   = '0;
        end
      end
      rows_due = {rows_due, scan_rows[i]};
    end
    @(negedge clk);
    smp.valid = 1'b0;
  endtask

  task automatic wait_quiet(input int settle);
    while (rows_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [CFG_DATA_BITS-1:0] data);
    // queued samples may still be folding in after the last row
    wait_quiet(SETTLE_CYCLES);
    cfg_ch.valid = 1'b1;
    cfg_ch.addr  = addr;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (addr)
      CFG_SECTOR_WIDTH:  cfg_width = data;
      CFG_CLIP_DISTANCE: cfg_clip  = data[DIST_BITS-1:0];
      CFG_NEAR_LIMIT:    cfg_near  = data[DIST_BITS-1:0];
      CFG_CLOSE_LIMIT:   cfg_close = data[DIST_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [DIST_BITS-1:0] pick_distance();
    int v;
    case ($urandom_range(4))
      0: v = $urandom_range(DIST_MAX);
      1: v = int'(cfg_clip) + int'($urandom_range(4)) - 2;
      2: v = int'(cfg_near) + int'($urandom_range(4)) - 2;
      3: v = int'(cfg_close) + int'($urandom_range(4)) - 2;
      default: v = $urandom_range(1) ? DIST_MAX : 0;
    endcase
    if (v < 0) v = 0;
    if (v > DIST_MAX) v = DIST_MAX;
    return DIST_BITS'(v);
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] limit_word(input int lim);
    return {3'($urandom), DIST_BITS'(lim)};
  endfunction

  function automatic int pick_limit();
    return $urandom_range(1) ? $urandom_range(2000) : $urandom_range(DIST_MAX);
  endfunction

  task automatic pick_config(input int phase);
    int w;
    int c;
    int nl;
    int cl;
    case (phase)
      0: begin
        w = 1; c = 0; nl = DIST_MAX; cl = DIST_MAX;
      end
      1: begin
        w = ANGLE_LAST + 1; c = DIST_MAX; nl = DIST_MAX; cl = 0;
      end
      default: begin
        case ($urandom_range(2))
          0: w = 60000;
          1: w = $urandom_range(5000, 70000);
          default: w = $urandom_range(1, ANGLE_LAST + 1);
        endcase
        c  = pick_limit();
        nl = pick_limit();
        cl = pick_limit();
      end
    endcase
    write_reg(CFG_SECTOR_WIDTH, CFG_DATA_BITS'(w));
    write_reg(CFG_CLIP_DISTANCE, limit_word(c));
    write_reg(CFG_NEAR_LIMIT, limit_word(nl));
    write_reg(CFG_CLOSE_LIMIT, limit_word(cl));
  endtask

  // rising sweeps with random content, now and then a stray request
  task automatic run_scans(input int items);
    int sent;
    int span;
    int ang;
    int len;
    sent = 0;
    span = (cfg_width == '0) ? ANGLE_LAST : int'(cfg_width) * (NUM_SECTORS + 1);
    if (span > ANGLE_LAST) span = ANGLE_LAST;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        send_sample(ANGLE_BITS'($urandom_range(ANGLE_LAST)), pick_distance());
        sent++;
      end else begin
        len = $urandom_range(2, 16);
        ang = $urandom_range(span / 8);
        for (int i = 0; i < len && sent < items; i++) begin
          send_sample(ANGLE_BITS'(ang), pick_distance());
          sent++;
          ang += $urandom_range(2 * span / len);
          if (ang > ANGLE_LAST) ang = ANGLE_LAST;
        end
      end
    end
  endtask

  // output side: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready = 1'b0;
    end else begin
      res.ready = no_idle || ($urandom_range(99) >= 32);
    end
  end

  function automatic void check_field(input string field, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s expected %0d got %0d", field, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      if (rows_due.size() == 0) begin
        $error("sector row %0d arrived with nothing expected", res.sector_index);
        mismatches++;
      end else begin
        want = rows_due.pop_front();
        check_field("sector_index", 32'(want.sector_index), 32'(res.sector_index));
        check_field("sector_average", 32'(want.sector_average), 32'(res.sector_average));
        check_field("average_valid", 32'(want.average_valid), 32'(res.average_valid));
        check_field("near_hits", 32'(want.near_hits), 32'(res.near_hits));
        check_field("sector_total", 32'(want.sector_total), 32'(res.sector_total));
        check_field("close_hits", 32'(want.close_hits), 32'(res.close_hits));
        check_field("last_of_scan", 32'(want.last_of_scan), 32'(res.last_of_scan));
      end
    end
  end

  // ends a hung run: no request of any kind accepted for too long
  always @(posedge clk) begin
    if ((smp.valid && smp.ready) || (res.valid && res.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    smp.valid           = 1'b0;
    smp.sample_angle    = '0;
    smp.sample_distance = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.addr         = CFG_SECTOR_WIDTH;
    cfg_ch.data         = '0;
    cfg_width           = SECTOR_WIDTH_RST;
    cfg_clip            = CLIP_DISTANCE_RST;
    cfg_near            = NEAR_LIMIT_RST;
    cfg_close           = CLOSE_LIMIT_RST;
    last_angle          = '0;
    clear_sectors();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int k = 0; k < PLAN_LEN; k++) begin
      if (plan[k].kind == STEP_WRITE) begin
        write_reg(plan[k].addr, plan[k].data);
      end else begin
        send_sample(plan[k].angle, plan[k].dist_cm, plan[k].typed, plan[k].t_empty,
                    plan[k].t_close);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      pick_config(p);
      // output stalls while sweeps keep coming, so the input backs up
      if (p == 2) hold_req = 1'b1;
      run_scans(PHASE_ITEMS);
    end

    // one sector fed back to back, no idling anywhere
    write_reg(CFG_SECTOR_WIDTH, CFG_DATA_BITS'(FLOOD_BASE));
    write_reg(CFG_CLIP_DISTANCE, limit_word(DIST_MAX));
    write_reg(CFG_NEAR_LIMIT, limit_word(DIST_MAX));
    write_reg(CFG_CLOSE_LIMIT, limit_word(DIST_MAX));
    no_idle = 1'b1;
    for (int i = 0; i < FLOOD_ITEMS; i++) begin
      send_sample(ANGLE_BITS'(FLOOD_BASE + i), DIST_BITS'($urandom_range(65000, DIST_MAX)));
    end
    send_sample('0, '0);
    no_idle = 1'b0;

    wait_quiet(DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
